// ----- sv/lds_pkg.sv -----
// ----------------------------------------------------------------------------
// lds_pkg
// Shared widths, codes and controller/datapath bundles for the linear
// Diophantine solver.
// ----------------------------------------------------------------------------
package lds_pkg;

  // Significant bits of each input coefficient (8 to 32)
  localparam int COEF_WIDTH = 32;
  // Field widths of the request and result payloads
  localparam int FIELD_W    = 32;
  localparam int PART_W     = 64;
  // Internal value width: one bit above the coefficient width so that
  // the magnitude of the most negative coefficient stays representable
  localparam int DW         = COEF_WIDTH + 1;
  localparam int PW         = 2 * DW;
  localparam int CNT_W      = $clog2(COEF_WIDTH + 1);

  typedef enum logic [1:0] {
    STAT_SOLVED = 2'd0,
    STAT_NOSOL  = 2'd1,
    STAT_DEGEN  = 2'd2
  } lds_status_t;

  // Datapath operations, one per cycle
  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_DEGEN,
    OP_DIV_STEP,
    OP_DIV_C,
    OP_DIV_B,
    OP_DIV_A,
    OP_LATCH_Q,
    OP_MUL_S,
    OP_UPD_S,
    OP_MUL_T,
    OP_UPD_T,
    OP_FIN_C,
    OP_PART_X,
    OP_PART_Y,
    OP_STEP_X,
    OP_STEP_Y
  } lds_op_t;

  typedef struct packed {
    lds_op_t op;
  } lds_cmd_t;

  typedef struct packed {
    logic b_zero;
    logic r1_zero;
    logic div_done;
    logic rem_zero;
  } lds_sts_t;

endpackage

// ----- sv/lds_in_if.sv -----
// ----------------------------------------------------------------------------
// lds_in_if
// Request channel: coefficients and right-hand side of one equation.
// ----------------------------------------------------------------------------
interface lds_in_if
  import lds_pkg::*;
();
  logic                       valid;
  logic                       ready;
  logic signed [FIELD_W-1:0]  coef_x;
  logic signed [FIELD_W-1:0]  coef_y;
  logic signed [FIELD_W-1:0]  rhs;

  modport source (output valid, coef_x, coef_y, rhs, input ready);
  modport sink   (input valid, coef_x, coef_y, rhs, output ready);
endinterface

// ----- sv/lds_out_if.sv -----
// ----------------------------------------------------------------------------
// lds_out_if
// Result channel: status, gcd, particular solution and solution steps.
// ----------------------------------------------------------------------------
interface lds_out_if
  import lds_pkg::*;
();
  logic                       valid;
  logic                       ready;
  logic [1:0]                 status;
  logic signed [FIELD_W-1:0]  divisor;
  logic signed [PART_W-1:0]   particular_x;
  logic signed [PART_W-1:0]   particular_y;
  logic signed [FIELD_W-1:0]  step_x;
  logic signed [FIELD_W-1:0]  step_y;

  modport source (output valid, status, divisor, particular_x, particular_y,
                  step_x, step_y, input ready);
  modport sink   (input valid, status, divisor, particular_x, particular_y,
                  step_x, step_y, output ready);
endinterface

// ----- sv/lds_div.sv -----
// ----------------------------------------------------------------------------
// lds_div
// Sequential signed divider, truncating toward zero. Restoring radix-2 on
// magnitudes, one quotient bit per cycle; done pulses when results are valid.
// ----------------------------------------------------------------------------
module lds_div
  import lds_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic signed [DW-1:0] dividend,
  input  logic signed [DW-1:0] divisor,
  output logic                 done,
  output logic signed [DW-1:0] quo,
  output logic signed [DW-1:0] rem
);

  logic                   busy_r;
  logic                   done_r;
  logic [CNT_W-1:0]       cnt_r;
  logic [COEF_WIDTH-1:0]  den_r;
  logic [COEF_WIDTH-1:0]  quo_r;
  logic [COEF_WIDTH-1:0]  rem_r;
  logic                   neg_q_r;
  logic                   neg_r_r;

  logic signed [DW-1:0]   num_abs;
  logic signed [DW-1:0]   den_abs;
  logic [COEF_WIDTH:0]    part;
  logic [COEF_WIDTH+1:0]  diff;
  logic                   ge;
  logic [DW-1:0]          quo_ext;
  logic [DW-1:0]          rem_ext;

  assign num_abs = dividend[DW-1] ? -dividend : dividend;
  assign den_abs = divisor[DW-1]  ? -divisor  : divisor;

  assign part = {rem_r, quo_r[COEF_WIDTH-1]};
  assign diff = {1'b0, part} - {2'b00, den_r};
  assign ge   = ~diff[COEF_WIDTH+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(COEF_WIDTH);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      den_r   <= den_abs[COEF_WIDTH-1:0];
      quo_r   <= num_abs[COEF_WIDTH-1:0];
      rem_r   <= '0;
      neg_q_r <= dividend[DW-1] ^ divisor[DW-1];
      neg_r_r <= dividend[DW-1];
    end else if (busy_r) begin
      rem_r <= ge ? diff[COEF_WIDTH-1:0] : part[COEF_WIDTH-1:0];
      quo_r <= {quo_r[COEF_WIDTH-2:0], ge};
    end
  end

  assign quo_ext = {1'b0, quo_r};
  assign rem_ext = {1'b0, rem_r};
  assign quo  = neg_q_r ? -signed'(quo_ext) : signed'(quo_ext);
  assign rem  = neg_r_r ? -signed'(rem_ext) : signed'(rem_ext);
  assign done = done_r;

endmodule

// ----- sv/lds_dp.sv -----
// ----------------------------------------------------------------------------
// lds_dp
// Datapath: remainder sequence and Bezout registers, shared divider and
// multiplier, and the result registers.
// ----------------------------------------------------------------------------
module lds_dp
  import lds_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  lds_cmd_t                   cmd,
  output lds_sts_t                   sts,
  input  logic signed [FIELD_W-1:0]  coef_x,
  input  logic signed [FIELD_W-1:0]  coef_y,
  input  logic signed [FIELD_W-1:0]  rhs,
  output logic [1:0]                 status,
  output logic signed [FIELD_W-1:0]  divisor,
  output logic signed [PART_W-1:0]   particular_x,
  output logic signed [PART_W-1:0]   particular_y,
  output logic signed [FIELD_W-1:0]  step_x,
  output logic signed [FIELD_W-1:0]  step_y
);

  logic signed [DW-1:0]       a_r, b_r, c_r;
  logic signed [DW-1:0]       r0_r, r1_r, rn_r;
  logic signed [DW-1:0]       s0_r, s1_r, t0_r, t1_r;
  logic signed [DW-1:0]       q_r, k_r, prod_r;
  lds_status_t                status_r;
  logic signed [FIELD_W-1:0]  divisor_r, step_x_r, step_y_r;
  logic signed [PART_W-1:0]   px_r, py_r;

  logic                       div_start;
  logic signed [DW-1:0]       div_num, div_den;
  logic                       div_done;
  logic signed [DW-1:0]       div_quo, div_rem;

  logic signed [DW-1:0]       mul_a, mul_b;
  logic signed [PW-1:0]       prod;

  // Divider operand select
  always_comb begin
    div_start = 1'b0;
    div_num   = r0_r;
    div_den   = r1_r;
    case (cmd.op)
      OP_DIV_STEP: begin
        div_start = 1'b1;
      end
      OP_DIV_C: begin
        div_start = 1'b1;
        div_num   = c_r;
        div_den   = r0_r;
      end
      OP_DIV_B: begin
        div_start = 1'b1;
        div_num   = b_r;
        div_den   = r0_r;
      end
      OP_DIV_A: begin
        div_start = 1'b1;
        div_num   = a_r;
        div_den   = r0_r;
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  lds_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_num),
    .divisor  (div_den),
    .done     (div_done),
    .quo      (div_quo),
    .rem      (div_rem)
  );

  // Multiplier operand select
  always_comb begin
    mul_a = q_r;
    mul_b = s1_r;
    case (cmd.op)
      OP_MUL_T:  mul_b = t1_r;
      OP_PART_X: begin
        mul_a = k_r;
        mul_b = s0_r;
      end
      OP_PART_Y: begin
        mul_a = k_r;
        mul_b = t0_r;
      end
      default:   mul_b = s1_r;
    endcase
  end

  assign prod = mul_a * mul_b;

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        a_r       <= DW'(signed'(coef_x[COEF_WIDTH-1:0]));
        b_r       <= DW'(signed'(coef_y[COEF_WIDTH-1:0]));
        c_r       <= DW'(signed'(rhs[COEF_WIDTH-1:0]));
        r0_r      <= DW'(signed'(coef_x[COEF_WIDTH-1:0]));
        r1_r      <= DW'(signed'(coef_y[COEF_WIDTH-1:0]));
        s0_r      <= DW'(1);
        s1_r      <= '0;
        t0_r      <= '0;
        t1_r      <= DW'(1);
        status_r  <= STAT_SOLVED;
        divisor_r <= '0;
        px_r      <= '0;
        py_r      <= '0;
        step_x_r  <= '0;
        step_y_r  <= '0;
      end
      OP_DEGEN:   status_r <= STAT_DEGEN;
      OP_LATCH_Q: begin
        q_r  <= div_quo;
        rn_r <= div_rem;
      end
      OP_MUL_S,
      OP_MUL_T:   prod_r <= prod[DW-1:0];
      OP_UPD_S: begin
        s0_r <= s1_r;
        s1_r <= s0_r - prod_r;
      end
      OP_UPD_T: begin
        t0_r <= t1_r;
        t1_r <= t0_r - prod_r;
        r0_r <= r1_r;
        r1_r <= rn_r;
      end
      OP_FIN_C: begin
        divisor_r <= FIELD_W'(r0_r);
        k_r       <= div_quo;
        if (div_rem != '0) begin
          status_r <= STAT_NOSOL;
        end
      end
      OP_PART_X:  px_r     <= PART_W'(prod);
      OP_PART_Y:  py_r     <= PART_W'(prod);
      OP_STEP_X:  step_x_r <= FIELD_W'(div_quo);
      OP_STEP_Y:  step_y_r <= FIELD_W'(div_quo);
      default: begin
        q_r <= q_r;
      end
    endcase
  end

  assign sts.b_zero   = (b_r == '0);
  assign sts.r1_zero  = (r1_r == '0);
  assign sts.div_done = div_done;
  assign sts.rem_zero = (div_rem == '0);

  assign status       = status_r;
  assign divisor      = divisor_r;
  assign particular_x = px_r;
  assign particular_y = py_r;
  assign step_x       = step_x_r;
  assign step_y       = step_y_r;

endmodule

// ----- sv/lds_ctrl.sv -----
// ----------------------------------------------------------------------------
// lds_ctrl
// Controller: sequences the remainder loop, the final divisions and the
// request/result handshakes.
// ----------------------------------------------------------------------------
module lds_ctrl
  import lds_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  input  lds_sts_t  sts,
  output lds_cmd_t  cmd
);

  typedef enum logic [15:0] {
    S_IDLE   = 16'h0001,
    S_CHECK  = 16'h0002,
    S_LOOP   = 16'h0004,
    S_DWAIT  = 16'h0008,
    S_MULS   = 16'h0010,
    S_UPDS   = 16'h0020,
    S_MULT   = 16'h0040,
    S_UPDT   = 16'h0080,
    S_FWAIT  = 16'h0100,
    S_PARTX  = 16'h0200,
    S_PARTY  = 16'h0400,
    S_BSTART = 16'h0800,
    S_BWAIT  = 16'h1000,
    S_ASTART = 16'h2000,
    S_AWAIT  = 16'h4000,
    S_DONE   = 16'h8000
  } lds_state_t;

  lds_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd.op    = OP_NONE;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op    = OP_LOAD;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts.b_zero) begin
          cmd.op    = OP_DEGEN;
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_LOOP;
        end
      end
      S_LOOP: begin
        // last nonzero remainder sits in r0 once r1 reaches zero
        if (sts.r1_zero) begin
          cmd.op    = OP_DIV_C;
          state_nxt = S_FWAIT;
        end else begin
          cmd.op    = OP_DIV_STEP;
          state_nxt = S_DWAIT;
        end
      end
      S_DWAIT: begin
        if (sts.div_done) begin
          cmd.op    = OP_LATCH_Q;
          state_nxt = S_MULS;
        end
      end
      S_MULS: begin
        cmd.op    = OP_MUL_S;
        state_nxt = S_UPDS;
      end
      S_UPDS: begin
        cmd.op    = OP_UPD_S;
        state_nxt = S_MULT;
      end
      S_MULT: begin
        cmd.op    = OP_MUL_T;
        state_nxt = S_UPDT;
      end
      S_UPDT: begin
        cmd.op    = OP_UPD_T;
        state_nxt = S_LOOP;
      end
      S_FWAIT: begin
        if (sts.div_done) begin
          cmd.op    = OP_FIN_C;
          state_nxt = sts.rem_zero ? S_PARTX : S_DONE;
        end
      end
      S_PARTX: begin
        cmd.op    = OP_PART_X;
        state_nxt = S_PARTY;
      end
      S_PARTY: begin
        cmd.op    = OP_PART_Y;
        state_nxt = S_BSTART;
      end
      S_BSTART: begin
        cmd.op    = OP_DIV_B;
        state_nxt = S_BWAIT;
      end
      S_BWAIT: begin
        if (sts.div_done) begin
          cmd.op    = OP_STEP_X;
          state_nxt = S_ASTART;
        end
      end
      S_ASTART: begin
        cmd.op    = OP_DIV_A;
        state_nxt = S_AWAIT;
      end
      S_AWAIT: begin
        if (sts.div_done) begin
          cmd.op    = OP_STEP_Y;
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        // hold the result until taken
        if (out_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = (state_r == S_DONE);

endmodule

// ----- sv/linear_diophantine_solver.sv -----
// Requests: one request at a time; the next request is taken in S_IDLE, which the
//   controller enters again once the result leaves. The radix-2 divider produces one
//   quotient bit per cycle and is used once per step.
// Reset: synchronous active-low rst_n returns the controller to idle; no
//   result is pending after reset.
// ----------------------------------------------------------------------------
// linear_diophantine_solver
// Solves coef_x*X + coef_y*Y = rhs by the extended Euclidean algorithm.
// ----------------------------------------------------------------------------
module linear_diophantine_solver
  import lds_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  lds_in_if.sink     in_req,
  lds_out_if.source  out_res
);

  lds_cmd_t cmd;
  lds_sts_t sts;
  logic     in_ready;
  logic     out_valid;

  lds_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_req.valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_res.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  lds_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .sts          (sts),
    .coef_x       (in_req.coef_x),
    .coef_y       (in_req.coef_y),
    .rhs          (in_req.rhs),
    .status       (out_res.status),
    .divisor      (out_res.divisor),
    .particular_x (out_res.particular_x),
    .particular_y (out_res.particular_y),
    .step_x       (out_res.step_x),
    .step_y       (out_res.step_y)
  );

  assign in_req.ready  = in_ready;
  assign out_res.valid = out_valid;

endmodule
